FILE: sv/frame_period_window_monitor_macros.svh
// Assertion macros for the frame period window monitor.
// Simulation builds get the checks; SYNTHESIS builds get empty bodies.
`ifndef FRAME_PERIOD_WINDOW_MONITOR_MACROS_SVH
`define FRAME_PERIOD_WINDOW_MONITOR_MACROS_SVH

`ifndef SYNTHESIS

`define FPWM_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`define FPWM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define FPWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FPWM_ASSERT_NEVER(label, clk, rst, cond, msg)

`define FPWM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define FPWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: sv/fpwm_pkg.sv
// Package for the frame period window monitor: field widths, constants and
// the sequencer state type. No dependencies.
package fpwm_pkg;

  localparam int unsigned TICK_W    = 64;
  localparam int unsigned FREQ_W    = 32;
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned NS_W      = 30;
  localparam int unsigned DELTA_W   = 48;
  localparam int unsigned ELAPSED_W = 64;
  localparam int unsigned SUM_OUT_W = 55;
  localparam int unsigned RATE_W    = 53;

  localparam int unsigned WINDOW_DEFAULT = 120;

  localparam logic [FREQ_W-1:0]    FREQ_RESET = 32'd10000000;
  localparam logic [NS_W-1:0]      NS_PER_SEC = 30'd1000000000;
  localparam logic [DELTA_W-1:0]   DELTA_MAX  = '1;
  localparam logic [SUM_OUT_W-1:0] SUM_MAX    = '1;
  localparam logic [RATE_W-1:0]    RATE_MAX   = '1;

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_MUL_LO     = 9'b000000010,
    S_MUL_HI     = 9'b000000100,
    S_LOAD_DELTA = 9'b000001000,
    S_DIV_DELTA  = 9'b000010000,
    S_UPDATE     = 9'b000100000,
    S_LOAD_RATE  = 9'b001000000,
    S_DIV_RATE   = 9'b010000000,
    S_DONE       = 9'b100000000
  } state_t;

endpackage

FILE: sv/frame_period_window_monitor.sv
// Frame period window monitor; depends on fpwm_pkg and the assertion macros.
// A result is presented once its request has passed the multiply, divide, update and rate
// states; a zero frequency or a zero window sum skips a division.
// One request is in flight at a time and the next can be taken in the same cycle the result
// appears; request spacing is set by the two bit-serial divisions and any result stall.
// Reset clears control state and sets 10 MHz; ring entries read as zero until first wrap.
`include "frame_period_window_monitor_macros.svh"

module frame_period_window_monitor #(
  parameter int unsigned WINDOW = fpwm_pkg::WINDOW_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fpwm_pkg::FREQ_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fpwm_pkg::TICK_W-1:0]      tick_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fpwm_pkg::DELTA_W-1:0]     frame_delta_ns,
  output logic [fpwm_pkg::ELAPSED_W-1:0]   elapsed_ns,
  output logic [fpwm_pkg::SUM_OUT_W-1:0]   window_sum_ns,
  output logic [fpwm_pkg::RATE_W-1:0]      frame_rate_q16
);

  import fpwm_pkg::*;

  localparam int unsigned PP_W    = HALF_W + NS_W;
  localparam int unsigned PROD_W  = TICK_W + NS_W;
  localparam int unsigned POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W   = $clog2(WINDOW) + DELTA_W;
  localparam int unsigned SUMX_W  = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam logic [63:0] RATE_NUM = 64'(WINDOW) * 64'(NS_PER_SEC) * 64'd65536;
  localparam int unsigned NUM_W   = $clog2(RATE_NUM + 64'd1);
  localparam int unsigned DVD_W   = (PROD_W > NUM_W) ? PROD_W : NUM_W;
  localparam int unsigned DVS_W   = (SUM_W > FREQ_W) ? SUM_W : FREQ_W;
  localparam int unsigned CNT_W   = $clog2(DVD_W + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  state_t                state;
  logic [FREQ_W-1:0]     tick_frequency_hz;
  logic [TICK_W-1:0]     previous_tick;
  logic [TICK_W-1:0]     diff;
  logic [PP_W-1:0]       prod_lo;
  logic [PP_W-1:0]       prod_hi;
  logic [ELAPSED_W-1:0]  elapsed_total;
  logic [SUM_W-1:0]      window_total;
  logic [DELTA_W-1:0]    delta;
  logic [POS_W-1:0]      ring_pos;
  logic                  ring_wrapped;

  logic [DELTA_W-1:0]    ring_mem [WINDOW];
  logic [DELTA_W-1:0]    ring_rd;
  logic                  ring_re;
  logic                  ring_we;

  logic [DVD_W-1:0]      dvd;
  logic [DVD_W-1:0]      quo;
  logic [DVS_W-1:0]      rem;
  logic [DVS_W-1:0]      divisor;
  logic [CNT_W-1:0]      count;

  logic [DVS_W:0]        rem_shift;
  logic                  fits;
  logic [DVS_W-1:0]      rem_next;
  logic [PROD_W-1:0]     product;
  logic [DELTA_W-1:0]    delta_sel;
  logic [DELTA_W-1:0]    ring_old;
  logic [SUMX_W-1:0]     sum_ext;
  logic [RATE_W-1:0]     rate_sel;
  logic                  out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign ring_re   = in_valid && in_ready;
  assign ring_we   = (state == S_UPDATE);

  assign rem_shift = {rem, dvd[DVD_W-1]};
  assign fits      = rem_shift >= {1'b0, divisor};
  assign rem_next  = fits ? DVS_W'(rem_shift - {1'b0, divisor}) : rem_shift[DVS_W-1:0];
  assign product   = PROD_W'(prod_lo) + (PROD_W'(prod_hi) << HALF_W);
  assign delta_sel = (quo[DVD_W-1:DELTA_W] != '0) ? DELTA_MAX : quo[DELTA_W-1:0];
  assign ring_old  = ring_wrapped ? ring_rd : '0;
  assign sum_ext   = SUMX_W'(window_total);
  assign rate_sel  = (quo > DVD_W'(RATE_MAX)) ? RATE_MAX : quo[RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_pos] <= delta_sel;
    end
    if (ring_re) begin
      ring_rd <= ring_mem[ring_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_frequency_hz <= FREQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tick_frequency_hz <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      previous_tick <= '0;
      elapsed_total <= '0;
      window_total  <= '0;
      ring_pos      <= '0;
      ring_wrapped  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            diff          <= tick_count - previous_tick;
            previous_tick <= tick_count;
            state         <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          prod_lo <= PP_W'(diff[HALF_W-1:0]) * PP_W'(NS_PER_SEC);
          state   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_hi <= PP_W'(diff[TICK_W-1:HALF_W]) * PP_W'(NS_PER_SEC);
          state   <= S_LOAD_DELTA;
        end
        S_LOAD_DELTA: begin
          if (tick_frequency_hz == '0) begin
            quo   <= '1;
            state <= S_UPDATE;
          end else begin
            dvd     <= DVD_W'(product) << (DVD_W - PROD_W);
            divisor <= DVS_W'(tick_frequency_hz);
            rem     <= '0;
            quo     <= '0;
            count   <= CNT_W'(PROD_W);
            state   <= S_DIV_DELTA;
          end
        end
        S_DIV_DELTA, S_DIV_RATE: begin
          rem   <= rem_next;
          dvd   <= dvd << 1;
          quo   <= {quo[DVD_W-2:0], fits};
          count <= count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state <= (state == S_DIV_DELTA) ? S_UPDATE : S_DONE;
          end
        end
        S_UPDATE: begin
          delta         <= delta_sel;
          elapsed_total <= elapsed_total + ELAPSED_W'(delta_sel);
          window_total  <= window_total - SUM_W'(ring_old) + SUM_W'(delta_sel);
          if (ring_pos == POS_LAST) begin
            ring_pos     <= '0;
            ring_wrapped <= 1'b1;
          end else begin
            ring_pos <= ring_pos + POS_W'(1);
          end
          state <= S_LOAD_RATE;
        end
        S_LOAD_RATE: begin
          if (window_total == '0) begin
            quo   <= '1;
            state <= S_DONE;
          end else begin
            dvd     <= DVD_W'(RATE_NUM) << (DVD_W - NUM_W);
            divisor <= DVS_W'(window_total);
            rem     <= '0;
            quo     <= '0;
            count   <= CNT_W'(NUM_W);
            state   <= S_DIV_RATE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            frame_delta_ns <= delta;
            elapsed_ns     <= elapsed_total;
            window_sum_ns  <= (sum_ext > SUMX_W'(SUM_MAX)) ? SUM_MAX
                                                          : sum_ext[SUM_OUT_W-1:0];
            frame_rate_q16 <= rate_sel;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FPWM_ASSERT_NEVER(a_ring_rw_apart, clk, rst, ring_re && ring_we, "ring read and write overlap")
  `FPWM_ASSERT_IMPLIES(a_result_from_done, clk, rst, $rose(out_valid), $past(state == S_DONE), "result raised outside the final step")
  `FPWM_ASSERT_IMPLIES(a_divisor_nonzero, clk, rst, state == S_DIV_DELTA || state == S_DIV_RATE, divisor != '0, "division by zero")
  `FPWM_ASSERT_IMPLIES(a_zero_sum_rate, clk, rst, out_valid && window_sum_ns == '0, frame_rate_q16 == RATE_MAX, "zero window sum without saturated rate")
  `FPWM_ASSERT_NEXT(a_accept_starts_work, clk, rst, in_valid && in_ready, state == S_MUL_LO, "request not taken into the multiplier")

endmodule

FILE: sim/fpwm_report_checker.sv
// Checker for the frame period window monitor: watches the configuration, request and result
// channels, predicts every result from the accepted requests and compares field by field.
// Depends on fpwm_pkg only.
`timescale 1ns / 1ps

module fpwm_report_checker #(
  parameter int unsigned WINDOW = fpwm_pkg::WINDOW_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fpwm_pkg::FREQ_W-1:0]    cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [fpwm_pkg::TICK_W-1:0]    tick_count,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [fpwm_pkg::DELTA_W-1:0]   frame_delta_ns,
  input  logic [fpwm_pkg::ELAPSED_W-1:0] elapsed_ns,
  input  logic [fpwm_pkg::SUM_OUT_W-1:0] window_sum_ns,
  input  logic [fpwm_pkg::RATE_W-1:0]    frame_rate_q16,
  output int unsigned                    failures
);
  import fpwm_pkg::*;

  typedef struct packed {
    logic [DELTA_W-1:0]   delta_ns;
    logic [ELAPSED_W-1:0] elapsed_ns;
    logic [SUM_OUT_W-1:0] window_sum_ns;
    logic [RATE_W-1:0]    rate_q16;
  } frame_report_t;

  localparam logic [63:0] RATE_NUMERATOR = 64'(WINDOW) * 64'(NS_PER_SEC) * 64'd65536;

  logic [FREQ_W-1:0]    tick_hz;
  logic [TICK_W-1:0]    last_tick;
  logic [ELAPSED_W-1:0] elapsed_acc;
  logic [63:0]          window_acc;
  logic [DELTA_W-1:0]   delta_hist [WINDOW];
  int unsigned          hist_pos;
  frame_report_t        pending_reports [$];
  frame_report_t        want_report;
  int unsigned          error_count = 0;

  function automatic logic [DELTA_W-1:0] ticks_to_delta_ns(input logic [TICK_W-1:0] diff,
                                                           input logic [FREQ_W-1:0] hz);
    logic [95:0] ns_product;
    logic [95:0] quotient;
    if (hz == '0) return DELTA_MAX;
    ns_product = 96'(diff) * 96'(NS_PER_SEC);
    quotient = ns_product / 96'(hz);
    if (quotient > 96'(DELTA_MAX)) return DELTA_MAX;
    return quotient[DELTA_W-1:0];
  endfunction

  task automatic account_frame(input logic [TICK_W-1:0] tick, output frame_report_t report);
    logic [DELTA_W-1:0] delta;
    logic [63:0]        rate;
    delta = ticks_to_delta_ns(tick - last_tick, tick_hz);
    elapsed_acc = elapsed_acc + 64'(delta);
    window_acc = window_acc - 64'(delta_hist[hist_pos]) + 64'(delta);
    delta_hist[hist_pos] = delta;
    hist_pos = (hist_pos == WINDOW - 1) ? 0 : hist_pos + 1;
    last_tick = tick;
    if (window_acc == 64'd0) begin
      rate = 64'(RATE_MAX);
    end else begin
      rate = RATE_NUMERATOR / window_acc;
      if (rate > 64'(RATE_MAX)) rate = 64'(RATE_MAX);
    end
    report.delta_ns = delta;
    report.elapsed_ns = elapsed_acc;
    report.window_sum_ns = (window_acc > 64'(SUM_MAX)) ? SUM_MAX : window_acc[SUM_OUT_W-1:0];
    report.rate_q16 = rate[RATE_W-1:0];
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tick_hz = FREQ_RESET;
      last_tick = '0;
      elapsed_acc = '0;
      window_acc = '0;
      hist_pos = 0;
      foreach (delta_hist[i]) delta_hist[i] = '0;
      pending_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none actual delta %0d",
                   $time, frame_delta_ns);
          error_count++;
        end else begin
          want_report = pending_reports.pop_front();
          check_field("frame_delta_ns", 64'(want_report.delta_ns), 64'(frame_delta_ns));
          check_field("elapsed_ns", want_report.elapsed_ns, elapsed_ns);
          check_field("window_sum_ns", 64'(want_report.window_sum_ns), 64'(window_sum_ns));
          check_field("frame_rate_q16", 64'(want_report.rate_q16), 64'(frame_rate_q16));
        end
      end
      if (cfg_valid && cfg_ready) tick_hz = cfg_data;
      if (in_valid && in_ready) begin
        account_frame(tick_count, want_report);
        pending_reports.push_back(want_report);
      end
    end
    // Results still owed count as failures, so the verdict sees any that never arrive.
    failures <= error_count + pending_reports.size();
  end

endmodule

FILE: sim/tb.sv
// Top level of the frame period window monitor testbench: clock, reset, stimulus and verdict.
// Depends on fpwm_pkg, the monitor itself and fpwm_report_checker.
`timescale 1ns / 1ps

module tb;
  import fpwm_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 90;
  localparam int unsigned FROZEN_RUN   = 125;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [FREQ_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [TICK_W-1:0]    tick_count;
  logic                 out_valid;
  logic                 out_ready;
  logic [DELTA_W-1:0]   frame_delta_ns;
  logic [ELAPSED_W-1:0] elapsed_ns;
  logic [SUM_OUT_W-1:0] window_sum_ns;
  logic [RATE_W-1:0]    frame_rate_q16;

  int unsigned       check_failures;
  int unsigned       sent_count = 0;
  int unsigned       received_count = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       burst_left = 0;
  logic [TICK_W-1:0] last_tick = '0;

  frame_period_window_monitor dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .tick_count     (tick_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_delta_ns (frame_delta_ns),
    .elapsed_ns     (elapsed_ns),
    .window_sum_ns  (window_sum_ns),
    .frame_rate_q16 (frame_rate_q16)
  );

  fpwm_report_checker report_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .tick_count     (tick_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_delta_ns (frame_delta_ns),
    .elapsed_ns     (elapsed_ns),
    .window_sum_ns  (window_sum_ns),
    .frame_rate_q16 (frame_rate_q16),
    .failures       (check_failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int unsigned hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        if (out_ready) begin
          out_ready <= 1'b0;
          hold = $urandom_range(1, 40);
        end else begin
          out_ready <= 1'b1;
          hold = $urandom_range(1, 250);
        end
      end else begin
        hold--;
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) received_count <= received_count + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_tick(input logic [TICK_W-1:0] value);
    in_valid <= 1'b1;
    tick_count <= value;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    last_tick = value;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (received_count != sent_count) @(posedge clk);
  endtask

  task automatic write_frequency(input logic [FREQ_W-1:0] hz);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= hz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [FREQ_W-1:0] phase_hz [PHASES];
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] next_tick;
    int unsigned       pick;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    tick_count = '0;
    phase_hz[0] = 32'd1;
    phase_hz[1] = 32'hFFFF_FFFF;
    phase_hz[2] = 32'd0;
    phase_hz[3] = 32'd1_000_000_000;
    phase_hz[4] = 32'd24_000_000;
    phase_hz[5] = FREQ_RESET;
    phase_hz[6] = $urandom;
    phase_hz[7] = $urandom_range(1, 1000);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // The first request counts from tick zero; then a wrap, a backwards step and exactly 1 s.
    send_tick(64'd0);
    send_tick(64'd0);
    send_tick(64'd1);
    send_tick(64'd166_667);
    send_tick('1);
    send_tick(64'd5);
    send_tick(64'd3);
    send_tick(64'h8000_0000_0000_0000);
    send_tick(64'h8000_0000_0098_9680);

    // At 1 Hz the delta sits just below and just above the 48-bit ceiling.
    write_frequency(32'd1);
    send_tick(last_tick + 64'd1);
    send_tick(last_tick + 64'd281_474);
    send_tick(last_tick + 64'd281_475);

    write_frequency(32'hFFFF_FFFF);
    send_tick(last_tick + 64'hFFFF_FFFF);
    send_tick(last_tick + 64'd1);
    send_tick(last_tick - 64'd1);

    // A zero frequency saturates every delta, even with no ticks elapsed.
    write_frequency(32'd0);
    send_tick(last_tick);
    send_tick(last_tick + 64'd1);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      write_frequency(phase_hz[phase]);
      // A stopped counter for longer than the window brings the window sum back to zero.
      if (phase == 4) begin
        for (int unsigned n = 0; n < FROZEN_RUN; n++) send_tick(last_tick);
      end
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        period = 64'(phase_hz[phase]) / 64'($urandom_range(24, 240)) + 64'd1;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          next_tick = last_tick + period + 64'($urandom_range(0, 1000));
        end else if (pick < 78) begin
          next_tick = last_tick;
        end else if (pick < 86) begin
          next_tick = last_tick - 64'($urandom_range(1, 100000));
        end else if (pick < 94) begin
          next_tick = {$urandom, $urandom};
        end else begin
          next_tick = last_tick + ({$urandom, $urandom} >> $urandom_range(0, 63));
        end
        send_tick(next_tick);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (check_failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/fpwm_pkg.sv
sv/frame_period_window_monitor.sv
sim/fpwm_report_checker.sv
sim/tb.sv
